[rtl/jnds_pkg.sv]
// Shared types and constants for the JSON nesting depth scanner.
// Used by every module under rtl/; has no dependencies of its own.
`timescale 1ns / 1ps

package jnds_pkg;

  localparam int unsigned BYTE_W = 8;

  // Character codes that steer the scan.
  localparam logic [BYTE_W-1:0] CHAR_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CHAR_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CHAR_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CHAR_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_BSLASH = 8'h5C;

  localparam logic [BYTE_W-1:0] DEPTH_LIMIT_RESET = 8'd64;

  // One registered input byte handed to the scan stage.
  typedef struct packed {
    logic              step;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;
  } scan_item_t;

  // Result of one message.
  typedef struct packed {
    logic [BYTE_W-1:0] max_depth;
    logic              over_limit;
  } scan_result_t;

endpackage

[rtl/jnds_scan.sv]
// Per-message scan state (quote, escape, depth counters, stop flag) and its update.
// Depends on jnds_pkg.
`timescale 1ns / 1ps

module jnds_scan import jnds_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_item_t        item_i,
  input  logic [BYTE_W-1:0] depth_limit_i,
  output scan_result_t      result_o
);

  localparam int unsigned CMP_W = (DEPTH_BITS > BYTE_W) ? DEPTH_BITS : BYTE_W;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
  localparam logic [CMP_W-1:0] BYTE_MAX = CMP_W'({BYTE_W{1'b1}});

  logic                  in_quote_q, in_quote_d;
  logic                  escape_q, escape_d;
  logic [DEPTH_BITS-1:0] cur_q, cur_d;
  logic [DEPTH_BITS-1:0] deepest_q, deepest_d;
  logic                  stopped_q, stopped_d;

  logic                  is_open, is_close;
  logic [DEPTH_BITS-1:0] cur_inc;
  logic [CMP_W-1:0]      deepest_ext;

  assign is_open  = (item_i.text_byte == CHAR_LBRACK) || (item_i.text_byte == CHAR_LBRACE);
  assign is_close = (item_i.text_byte == CHAR_RBRACK) || (item_i.text_byte == CHAR_RBRACE);
  assign cur_inc  = (cur_q < DEPTH_MAX) ? cur_q + 1'b1 : cur_q;

  // Scanned values for this byte; a stopped message keeps its state.
  always_comb begin
    in_quote_d = in_quote_q;
    escape_d   = escape_q;
    cur_d      = cur_q;
    deepest_d  = deepest_q;
    stopped_d  = stopped_q;
    if (!stopped_q) begin
      if (in_quote_q) begin
        priority if (escape_q) begin
          escape_d = 1'b0;
        end else if (item_i.text_byte == CHAR_BSLASH) begin
          escape_d = 1'b1;
        end else if (item_i.text_byte == CHAR_QUOTE) begin
          in_quote_d = 1'b0;
        end else begin
          escape_d = escape_q;
        end
      end else begin
        priority if (item_i.text_byte == CHAR_QUOTE) begin
          in_quote_d = 1'b1;
        end else if (is_open) begin
          cur_d = cur_inc;
          if (cur_inc > deepest_q) begin
            deepest_d = cur_inc;
            if (CMP_W'(cur_inc) > CMP_W'(depth_limit_i)) begin
              stopped_d = 1'b1;
            end
          end
        end else if (is_close) begin
          if (cur_q != '0) begin
            cur_d = cur_q - 1'b1;
          end
        end else begin
          cur_d = cur_q;
        end
      end
    end
  end

  // The result reflects the byte just scanned; the output stage only keeps it on a last byte.
  assign deepest_ext          = CMP_W'(deepest_d);
  assign result_o.max_depth   = (deepest_ext > BYTE_MAX) ? {BYTE_W{1'b1}}
                                                         : deepest_ext[BYTE_W-1:0];
  assign result_o.over_limit  = stopped_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q <= 1'b0;
      escape_q   <= 1'b0;
      cur_q      <= '0;
      deepest_q  <= '0;
      stopped_q  <= 1'b0;
    end else if (item_i.step) begin
      if (item_i.last_byte) begin
        in_quote_q <= 1'b0;
        escape_q   <= 1'b0;
        cur_q      <= '0;
        deepest_q  <= '0;
        stopped_q  <= 1'b0;
      end else begin
        in_quote_q <= in_quote_d;
        escape_q   <= escape_d;
        cur_q      <= cur_d;
        deepest_q  <= deepest_d;
        stopped_q  <= stopped_d;
      end
    end
  end

endmodule

[rtl/jnds_out.sv]
// Result register for the master-side stream of the depth scanner.
// Depends on jnds_pkg.
`timescale 1ns / 1ps

module jnds_out import jnds_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  scan_result_t result_i,
  input  logic         ready_i,
  output logic         valid_o,
  output scan_result_t result_o
);

  logic         valid_q, valid_d;
  scan_result_t result_q;

  assign valid_d = load_i | (valid_q & ~ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

[rtl/json_nesting_depth_scanner.sv]
// Top level of the JSON nesting depth scanner: input register, scan stage, result register.
// Depends on jnds_pkg, jnds_scan and jnds_out.
`timescale 1ns / 1ps

// Usage:
// Bytes of a JSON message arrive on the slave stream, one per transfer, with
// s_axis_tlast on the final byte. Each message yields one result transfer on
// the master stream: the deepest bracket nesting in m_axis_tdata and the
// over-limit flag in m_axis_tuser.
// Throughput is one byte per cycle while the receiver does not hold back a final
// byte. A byte is held in the input register and scanned from there; as the last
// byte of a message leaves it, the result register that drives m_axis_tvalid is loaded.
// The depth limit is written through cfg_we_i / cfg_wdata_i while no message
// is in flight; it resets to 64.
// Reset clears the scan state, both stream valids and sets the limit to 64.
// When the receiver stalls, non-final bytes keep flowing; a final byte waits
// in the input register until the result register is free, and s_axis_tready
// drops for as long as it waits.
module json_nesting_depth_scanner import jnds_pkg::*; #(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] text_byte
  input  logic              s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] max_depth
  output logic              m_axis_tuser    // [0] over_limit
);

  logic [BYTE_W-1:0] depth_limit_q;
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              advance;
  logic              out_load;
  scan_item_t        item;
  scan_result_t      scan_res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= DEPTH_LIMIT_RESET;
    end else if (cfg_we_i) begin
      depth_limit_q <= cfg_wdata_i;
    end
  end

  // A held final byte moves on only when the result register can take its result.
  assign advance       = in_valid_q & ~(in_last_q & m_axis_tvalid & ~m_axis_tready);
  assign out_load      = advance & in_last_q;
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  assign item.step      = advance;
  assign item.text_byte = in_byte_q;
  assign item.last_byte = in_last_q;

  jnds_scan #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .depth_limit_i (depth_limit_q),
    .result_o      (scan_res)
  );

  jnds_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .result_i (scan_res),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .result_o (out_res)
  );

  assign m_axis_tdata = out_res.max_depth;
  assign m_axis_tuser = out_res.over_limit;

`ifndef SYNTHESIS
  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten while stalled");

  // A final byte waiting on a stalled output blocks the input side.
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_last_q && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while final byte is blocked");

  // A flagged result always reports a depth above the limit.
  a_flag_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata > depth_limit_q))
    else $error("over-limit flag set with depth within limit");
`endif

endmodule

[tb/tb_json_nesting_depth_scanner.sv]
// Self-checking testbench for json_nesting_depth_scanner: random JSON-like byte streams
// are checked against a nesting depth predictor. Depends on jnds_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_json_nesting_depth_scanner;
  import jnds_pkg::*;

  localparam int unsigned DEPTH_BITS     = 8;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned PHASE_ITEMS    = 70;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [BYTE_W-1:0] cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [BYTE_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  json_nesting_depth_scanner #(
    .DEPTH_BITS(DEPTH_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Tracks the scan state of the current message and queues the result of each message.
  class depth_scoreboard;
    logic [BYTE_W-1:0]     limit;
    logic                  in_string;
    logic                  escaped;
    logic                  halted;
    logic [DEPTH_BITS-1:0] depth;
    logic [DEPTH_BITS-1:0] deepest;
    scan_result_t          expected_results[$];
    int                    errors;

    function new();
      limit  = DEPTH_LIMIT_RESET;
      errors = 0;
      clear_message();
    endfunction

    function void clear_message();
      in_string = 1'b0;
      escaped   = 1'b0;
      halted    = 1'b0;
      depth     = '0;
      deepest   = '0;
    endfunction

    function void set_limit(logic [BYTE_W-1:0] value);
      limit = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      scan_result_t res;
      // Once the limit has been exceeded, the rest of the message is not scanned.
      if (!halted) begin
        if (in_string) begin
          if (escaped) escaped = 1'b0;
          else if (b == CHAR_BSLASH) escaped = 1'b1;
          else if (b == CHAR_QUOTE) in_string = 1'b0;
        end else if (b == CHAR_QUOTE) begin
          in_string = 1'b1;
        end else if (b == CHAR_LBRACK || b == CHAR_LBRACE) begin
          if (depth != {DEPTH_BITS{1'b1}}) depth = depth + 1'b1;
          if (depth > deepest) begin
            deepest = depth;
            if (deepest > limit) halted = 1'b1;
          end
        end else if (b == CHAR_RBRACK || b == CHAR_RBRACE) begin
          if (depth != '0) depth = depth - 1'b1;
        end
      end
      if (last) begin
        res.max_depth  = (deepest > 255) ? 8'hFF : BYTE_W'(deepest);
        res.over_limit = halted;
        expected_results = {expected_results, res};
        clear_message();
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [BYTE_W-1:0] max_depth, logic over_limit);
      scan_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none outstanding: max_depth=%0d over_limit=%0d",
                                  max_depth, over_limit));
        return;
      end
      want = expected_results.pop_front();
      if (max_depth !== want.max_depth)
        report_mismatch($sformatf("max_depth got %0d want %0d", max_depth, want.max_depth));
      if (over_limit !== want.over_limit)
        report_mismatch($sformatf("over_limit got %0d want %0d", over_limit, want.over_limit));
    endtask
  endclass

  depth_scoreboard sb;
  int unsigned     idle_cycles = 0;
  int unsigned     items_sent;
  int unsigned     burst_left;
  bit              hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are observed here, with the values that stood before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // The receiver alternates stretches of different stall density, plus one long hold-off.
  initial begin : receiver
    int unsigned mode;
    int unsigned len;
    bit          hold_done;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(5, 60);
      repeat (len) begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Offers one byte and returns at the edge where the transfer completes.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_random_message(input int unsigned max_len);
    int unsigned len;
    int unsigned style;
    int unsigned r;
    int unsigned open_w;
    logic [BYTE_W-1:0] b;
    style  = $urandom_range(0, 9);
    // Deep messages lean on opening brackets to reach the limit; noise ones are all random bytes.
    open_w = (style < 3) ? 55 : 30;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_len) : $urandom_range(1, 24);
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (style == 9) b = BYTE_W'($urandom_range(0, 255));
      else if (r < open_w / 2) b = CHAR_LBRACK;
      else if (r < open_w) b = CHAR_LBRACE;
      else if (r < open_w + 11) b = CHAR_RBRACK;
      else if (r < open_w + 20) b = CHAR_RBRACE;
      else if (r < open_w + 29) b = CHAR_QUOTE;
      else if (r < open_w + 36) b = CHAR_BSLASH;
      else b = BYTE_W'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic send_message(input logic [BYTE_W-1:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // The limit is only changed once every result is back and the pipeline has drained.
  task automatic write_depth_limit(input logic [BYTE_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(value);
  endtask

  initial begin : main
    logic [BYTE_W-1:0] msg[$];
    logic [BYTE_W-1:0] limits[$];
    int unsigned       start_items;
    sb          = new();
    items_sent  = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset limit: single-byte message, escapes inside strings,
    // brackets hidden in strings, closing below zero.
    msg = '{8'h00};
    send_message(msg);
    msg = '{8'hFF, CHAR_LBRACK, CHAR_LBRACE, CHAR_QUOTE, CHAR_LBRACK, CHAR_BSLASH, CHAR_QUOTE,
            CHAR_RBRACK, CHAR_QUOTE, CHAR_RBRACE, CHAR_RBRACK};
    send_message(msg);
    msg = '{CHAR_RBRACK, CHAR_RBRACE, CHAR_LBRACK};
    send_message(msg);
    msg = '{CHAR_QUOTE, CHAR_BSLASH, CHAR_BSLASH, CHAR_QUOTE, CHAR_LBRACK};
    send_message(msg);

    // Zero limit: the first bracket stops the scan, and a final bracket is scanned first.
    write_depth_limit(8'd0);
    msg = '{CHAR_LBRACK, CHAR_RBRACK, CHAR_LBRACK};
    send_message(msg);
    msg = '{CHAR_LBRACE};
    send_message(msg);

    limits = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd254, 8'd5, 8'd64, 8'd8, 8'd0, 8'd1};
    for (int p = 0; p < limits.size() + 2; p++) begin
      if (p < limits.size()) write_depth_limit(limits[p]);
      else write_depth_limit(BYTE_W'($urandom_range(0, 12)));
      if (p == 3) hold_req = 1'b1;
      if (limits[p % limits.size()] == 8'd254 && p < limits.size()) begin
        // Deepest possible nesting: one past the limit at the counter ceiling, and just at it.
        msg.delete();
        repeat (255) msg = {msg, CHAR_LBRACK};
        send_message(msg);
        msg.delete();
        repeat (254) msg = {msg, CHAR_LBRACE};
        msg = {msg, CHAR_RBRACE};
        send_message(msg);
      end
      start_items = items_sent;
      while (items_sent - start_items < PHASE_ITEMS) send_random_message(80);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
rtl/jnds_pkg.sv
rtl/jnds_scan.sv
rtl/jnds_out.sv
rtl/json_nesting_depth_scanner.sv
tb/tb_json_nesting_depth_scanner.sv
